// ----- sv/assert_macros.svh -----
// Assertion macros for the SD SPI block reader RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SDBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sdbr: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define SDBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sdbr: next-cycle check failed");

`endif

// ----- sv/sdbr_pkg.sv -----
// Package for the SD SPI block reader: item types, codes and constants.
// No dependencies; used by the interfaces, the sequencer and the top level.
package sdbr_pkg;

    // Block size in bytes; must be a power of two (16 to 4096).
    localparam int BLOCK_BYTES = 512;
    localparam int BLOCK_BITS  = $clog2(BLOCK_BYTES);
    // Wake-up bytes sent before chip select (1 to 15).
    localparam int WAKE_BYTES  = 10;
    localparam logic [3:0] WAKE_LIMIT = 4'(WAKE_BYTES);

    // Request codes
    localparam logic [1:0] FUNC_INIT  = 2'd0;
    localparam logic [1:0] FUNC_OPEN  = 2'd1;
    localparam logic [1:0] FUNC_FETCH = 2'd2;
    localparam logic [1:0] FUNC_DONE  = 2'd3;

    // Command indexes
    localparam logic [5:0] CMD_RESET = 6'd0;
    localparam logic [5:0] CMD_INIT  = 6'd1;
    localparam logic [5:0] CMD_READ  = 6'd17;

    localparam logic [2:0] FRAME_LAST = 3'd7;
    localparam logic [2:0] CRC_LEN    = 3'd2;

    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] BYTE_START = 8'h40;
    localparam logic [7:0] BYTE_CRC   = 8'h95;
    localparam logic [7:0] BYTE_TOKEN = 8'hFE;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_WAKE  = 7'b0000010,
        PH_FRAME = 7'b0000100,
        PH_POLL  = 7'b0001000,
        PH_TOKEN = 7'b0010000,
        PH_DATA  = 7'b0100000,
        PH_CRC   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [7:0]  rx_byte;
    } t_req;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       card_select;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       response_valid;
        logic [7:0] response_code;
        logic       ready_res;
    } t_res;

endpackage

// ----- sv/sdbr_if.sv -----
// Valid/ready channels for request and result items of the block reader.
// Depends on sdbr_pkg for the payload structs.
interface sdbr_req_if import sdbr_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdbr_res_if import sdbr_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/sdbr_seq.sv -----
// Byte sequencer state for the SD SPI block reader: phase, address, counters.
// Depends on sdbr_pkg; result is combinational from the accepted item.
module sdbr_seq import sdbr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_req i_req,
    output t_res o_res
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_addr, n_addr;
    logic [2:0]  r_frame, n_frame;
    logic [3:0]  r_wake, n_wake;
    logic [5:0]  r_cmd, n_cmd;
    logic        r_sel, n_sel;

    logic [3:0]  wake_inc;
    logic [2:0]  frame_inc;
    logic [31:0] addr_inc;
    logic [31:0] arg;
    logic [7:0]  frame_byte;
    logic        dvalid, rvalid;

    assign wake_inc  = r_wake + 4'd1;
    assign frame_inc = r_frame + 3'd1;
    assign addr_inc  = r_addr + 32'd1;

    // Advance the sequencer for one item
    always_comb begin
        n_phase = r_phase;
        n_addr  = r_addr;
        n_frame = r_frame;
        n_wake  = r_wake;
        n_cmd   = r_cmd;
        n_sel   = r_sel;
        dvalid  = 1'b0;
        rvalid  = 1'b0;
        if (r_phase == PH_IDLE) begin
            case (i_req.func)
                FUNC_INIT: begin
                    n_sel   = 1'b0;
                    n_wake  = 4'd0;
                    n_phase = PH_WAKE;
                end
                FUNC_OPEN: begin
                    n_addr  = i_req.address;
                    n_cmd   = CMD_READ;
                    n_frame = 3'd0;
                    n_phase = PH_FRAME;
                end
                FUNC_FETCH: begin
                    n_phase = PH_DATA;
                end
                default: ;
            endcase
        end else if (i_req.func == FUNC_DONE) begin
            case (r_phase)
                PH_WAKE: begin
                    n_wake = wake_inc;
                    if (wake_inc >= WAKE_LIMIT) begin
                        n_sel   = 1'b1;
                        n_cmd   = CMD_RESET;
                        n_frame = 3'd0;
                        n_phase = PH_FRAME;
                    end
                end
                PH_FRAME: begin
                    if (frame_inc >= FRAME_LAST) begin
                        n_frame = 3'd0;
                        n_phase = PH_POLL;
                    end else begin
                        n_frame = frame_inc;
                    end
                end
                PH_POLL: begin
                    if (i_req.rx_byte != BYTE_IDLE) begin
                        rvalid = 1'b1;
                        if (r_cmd == CMD_RESET) begin
                            n_cmd   = CMD_INIT;
                            n_frame = 3'd0;
                            n_phase = PH_FRAME;
                        end else if (r_cmd == CMD_READ) begin
                            n_phase = PH_TOKEN;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_TOKEN: begin
                    if (i_req.rx_byte == BYTE_TOKEN) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_DATA: begin
                    dvalid = 1'b1;
                    n_addr = addr_inc;
                    // block boundary: skip CRC then reissue the read
                    if (addr_inc[BLOCK_BITS-1:0] == '0) begin
                        n_frame = 3'd0;
                        n_phase = PH_CRC;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_CRC: begin
                    n_frame = frame_inc;
                    if (frame_inc >= CRC_LEN) begin
                        n_cmd   = CMD_READ;
                        n_frame = 3'd0;
                        n_phase = PH_FRAME;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Pick the frame byte from the updated state
    assign arg = (n_cmd == CMD_READ) ? n_addr : 32'd0;
    always_comb begin
        case (n_frame)
            3'd0:    frame_byte = BYTE_IDLE;
            3'd1:    frame_byte = BYTE_START | {2'b00, n_cmd};
            3'd2:    frame_byte = arg[31:24];
            3'd3:    frame_byte = arg[23:16];
            3'd4:    frame_byte = arg[15:8];
            3'd5:    frame_byte = arg[7:0];
            default: frame_byte = BYTE_CRC;
        endcase
    end

    // Form the result item
    always_comb begin
        o_res.tx_valid       = (n_phase != PH_IDLE);
        o_res.tx_byte        = (n_phase == PH_FRAME) ? frame_byte : BYTE_IDLE;
        o_res.card_select    = n_sel;
        o_res.data_valid     = dvalid;
        o_res.data_byte      = dvalid ? i_req.rx_byte : 8'd0;
        o_res.response_valid = rvalid;
        o_res.response_code  = rvalid ? i_req.rx_byte : 8'd0;
        o_res.ready_res      = (n_phase == PH_IDLE);
    end

    // Hold state unless an item is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_addr  <= 32'd0;
            r_frame <= 3'd0;
            r_wake  <= 4'd0;
            r_cmd   <= CMD_RESET;
            r_sel   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_frame <= n_frame;
            r_wake  <= n_wake;
            r_cmd   <= n_cmd;
            r_sel   <= n_sel;
        end
    end

endmodule

// ----- sv/sd_spi_block_reader.sv -----
// Top level of the SD SPI block reader: sequencer plus two-entry result buffer.
// Depends on sdbr_pkg, sdbr_if.sv, sdbr_seq and assert_macros.svh.
//
//   channel | dir | modport | payload
//   i_req   | in  | sink    | func, address, rx_byte
//   o_res   | out | source  | tx_valid, tx_byte, card_select, data_valid,
//           |     |         | data_byte, response_valid, response_code, ready_res
//
// Each request item yields one result item in the result register or skid entry.
// One item per cycle is taken while i_req ready is high, updating sequencer state.
// A result register and a skid entry hold results while o_res stalls; i_req
// ready drops only when both are full.
// Reset is synchronous, active low, and clears the phase, counters and buffer.
`include "assert_macros.svh"

module sd_spi_block_reader import sdbr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdbr_req_if.sink   i_req,
    sdbr_res_if.source o_res
);

    logic r_main_valid, n_main_valid;
    logic r_skid_valid, n_skid_valid;
    t_res r_main, n_main;
    t_res r_skid;
    t_res seq_res;
    logic in_acc, out_take;

    assign i_req.ready = !r_skid_valid;
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_take    = o_res.valid && o_res.ready;
    assign o_res.valid = r_main_valid;
    assign o_res.data  = r_main;

    sdbr_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_req    (i_req.data),
        .o_res    (seq_res)
    );

    // Route a new result into the main register or the skid entry
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        if (out_take) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = in_acc;
                n_main       = seq_res;
            end
        end else if (in_acc) begin
            if (!r_main_valid) begin
                n_main_valid = 1'b1;
                n_main       = seq_res;
            end else begin
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        if (in_acc && r_main_valid && !out_take) begin
            r_skid <= seq_res;
        end
    end

    `SDBR_ASSERT_NOW(a_skid_needs_main, i_clk, i_rst_n, r_skid_valid, r_main_valid)
    `SDBR_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, in_acc && r_main_valid && !out_take, r_skid_valid)
    `SDBR_ASSERT_NOW(a_ready_vs_tx, i_clk, i_rst_n, r_main_valid, r_main.ready_res != r_main.tx_valid)
    `SDBR_ASSERT_NOW(a_one_report, i_clk, i_rst_n, r_main_valid, !(r_main.data_valid && r_main.response_valid))

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for sd_spi_block_reader: drives request items, predicts
// each result item and checks it field by field on the result channel.
// Depends on sdbr_pkg and the sdbr_req_if / sdbr_res_if interfaces.
module tb import sdbr_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT     = 24;
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 800;
    localparam int PRINT_CAP    = 100;

    // Card sequencer predictor and store of expected result items
    class sdbr_scoreboard;
        t_phase      phase;
        logic [31:0] cur_addr;
        logic [2:0]  frame_idx;
        logic [3:0]  wake_cnt;
        logic [5:0]  pend_cmd;
        logic        sel;
        t_res        expected_q[$];
        int          errors;
        int          n_checked;
        int          n_data;
        int          n_replies;
        int          n_inits;
        int          n_crossings;
        int          n_wraps;

        function new();
            phase     = PH_IDLE;
            cur_addr  = '0;
            frame_idx = '0;
            wake_cnt  = '0;
            pend_cmd  = '0;
            sel       = 1'b0;
            errors    = 0;
            n_checked = 0;
            n_data    = 0;
            n_replies = 0;
            n_inits   = 0;
            n_crossings = 0;
            n_wraps   = 0;
        endfunction

        function void start_frame(logic [5:0] cmd);
            pend_cmd  = cmd;
            frame_idx = '0;
            phase     = PH_FRAME;
        endfunction

        // Byte of the command frame at the current frame index
        function logic [7:0] frame_byte();
            logic [31:0] arg;
            arg = (pend_cmd == CMD_READ) ? cur_addr : 32'h0;
            case (frame_idx)
                3'd0: return BYTE_IDLE;
                3'd1: return BYTE_START | {2'b00, pend_cmd};
                3'd2: return arg[31:24];
                3'd3: return arg[23:16];
                3'd4: return arg[15:8];
                3'd5: return arg[7:0];
                default: return BYTE_CRC;
            endcase
        endfunction

        // Advance the sequencer by one accepted item and queue its result;
        // return 1 when the item had an effect, 0 when it was ignored
        function bit note_request(t_req r);
            t_res e;
            bit   acted;
            e     = '0;
            acted = 1'b1;
            if (phase == PH_IDLE) begin
                case (r.func)
                    FUNC_INIT: begin
                        sel      = 1'b0;
                        wake_cnt = '0;
                        phase    = PH_WAKE;
                        n_inits++;
                    end
                    FUNC_OPEN: begin
                        cur_addr = r.address;
                        start_frame(CMD_READ);
                    end
                    FUNC_FETCH: phase = PH_DATA;
                    default: acted = 1'b0;
                endcase
            end else if (r.func == FUNC_DONE) begin
                case (phase)
                    PH_WAKE: begin
                        wake_cnt = wake_cnt + 4'd1;
                        if (wake_cnt >= WAKE_LIMIT) begin
                            sel = 1'b1;
                            start_frame(CMD_RESET);
                        end
                    end
                    PH_FRAME: begin
                        frame_idx = frame_idx + 3'd1;
                        if (frame_idx >= FRAME_LAST) begin
                            frame_idx = '0;
                            phase     = PH_POLL;
                        end
                    end
                    PH_POLL: begin
                        if (r.rx_byte != BYTE_IDLE) begin
                            e.response_valid = 1'b1;
                            e.response_code  = r.rx_byte;
                            n_replies++;
                            if (pend_cmd == CMD_RESET)
                                start_frame(CMD_INIT);
                            else if (pend_cmd == CMD_READ)
                                phase = PH_TOKEN;
                            else
                                phase = PH_IDLE;
                        end
                    end
                    PH_TOKEN: begin
                        if (r.rx_byte == BYTE_TOKEN)
                            phase = PH_IDLE;
                    end
                    PH_DATA: begin
                        e.data_valid = 1'b1;
                        e.data_byte  = r.rx_byte;
                        n_data++;
                        cur_addr = cur_addr + 32'd1;
                        if (cur_addr == 32'h0)
                            n_wraps++;
                        if ((cur_addr % BLOCK_BYTES) == 0) begin
                            frame_idx = '0;
                            phase     = PH_CRC;
                            n_crossings++;
                        end else begin
                            phase = PH_IDLE;
                        end
                    end
                    PH_CRC: begin
                        frame_idx = frame_idx + 3'd1;
                        if (frame_idx >= CRC_LEN)
                            start_frame(CMD_READ);
                    end
                    default: phase = PH_IDLE;
                endcase
            end else begin
                acted = 1'b0;
            end
            e.tx_valid    = (phase != PH_IDLE);
            e.tx_byte     = (phase == PH_FRAME) ? frame_byte() : BYTE_IDLE;
            e.card_select = sel;
            e.ready_res   = (phase == PH_IDLE);
            expected_q.push_back(e);
            return acted;
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        endtask

        // Compare one result item against the oldest expectation
        task check_result(t_res got);
            t_res want;
            if (expected_q.size() == 0) begin
                report("unexpected result item", 32'(got), 32'h0);
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (got.tx_valid !== want.tx_valid)
                report("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
            if (got.tx_byte !== want.tx_byte)
                report("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
            if (got.card_select !== want.card_select)
                report("card_select", 32'(got.card_select), 32'(want.card_select));
            if (got.data_valid !== want.data_valid)
                report("data_valid", 32'(got.data_valid), 32'(want.data_valid));
            if (got.data_byte !== want.data_byte)
                report("data_byte", 32'(got.data_byte), 32'(want.data_byte));
            if (got.response_valid !== want.response_valid)
                report("response_valid", 32'(got.response_valid), 32'(want.response_valid));
            if (got.response_code !== want.response_code)
                report("response_code", 32'(got.response_code), 32'(want.response_code));
            if (got.ready_res !== want.ready_res)
                report("ready_res", 32'(got.ready_res), 32'(want.ready_res));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    sdbr_req_if req_if ();
    sdbr_res_if res_if ();

    sd_spi_block_reader dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    sdbr_scoreboard sb;
    t_req           script_q[$];
    bit             in_script = 1'b1;
    bit             nudged    = 1'b0;
    logic [7:0]     fetch_rx  = 8'h00;
    int             real_items  = 0;
    int             stall_cycles = 0;
    bit             stim_done = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_req make_req(logic [1:0] func, logic [31:0] addr, logic [7:0] rx);
        t_req r;
        r.func    = func;
        r.address = addr;
        r.rx_byte = rx;
        return r;
    endfunction

    // Pick an open address: aligned, near a block end, near the top, or anything
    function automatic logic [31:0] open_address();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
            return $urandom & ~(BLOCK_BYTES - 1);
        else if (pick < 75)
            return ($urandom & ~(BLOCK_BYTES - 1)) + BLOCK_BYTES - $urandom_range(6, 1);
        else if (pick < 85)
            return 32'hFFFF_FFFF - $urandom_range(3);
        else
            return $urandom;
    endfunction

    // Choose the next request item from the predicted phase of the card
    function automatic t_req next_request();
        int    roll;
        t_req  r;
        if (sb.phase == PH_IDLE) begin
            if (in_script && script_q.size() > 0) begin
                r = script_q.pop_front();
                fetch_rx = r.rx_byte;
                return r;
            end
            in_script = 1'b0;
            roll = $urandom_range(99);
            if (roll < 6)
                return make_req(FUNC_DONE, $urandom, 8'($urandom_range(255)));
            else if (roll < 12)
                return make_req(FUNC_INIT, $urandom, 8'($urandom_range(255)));
            else if (roll < 36)
                return make_req(FUNC_OPEN, open_address(), 8'($urandom_range(255)));
            else
                return make_req(FUNC_FETCH, $urandom, 8'($urandom_range(255)));
        end
        // Directed run: answer each exchange at once, poke one busy request
        if (in_script) begin
            if (sb.phase == PH_FRAME && sb.frame_idx == 3'd3 && !nudged) begin
                nudged = 1'b1;
                return make_req(FUNC_FETCH, 32'h0, 8'h00);
            end
            case (sb.phase)
                PH_POLL:  return make_req(FUNC_DONE, 32'h0, 8'h00);
                PH_TOKEN: return make_req(FUNC_DONE, 32'h0, BYTE_TOKEN);
                PH_DATA:  return make_req(FUNC_DONE, 32'h0, fetch_rx);
                default:  return make_req(FUNC_DONE, 32'h0, 8'h5A);
            endcase
        end
        // Random run: mostly well-formed exchanges, some ignored busy requests
        if ($urandom_range(99) < 8)
            return make_req(2'($urandom_range(2)), $urandom, 8'($urandom_range(255)));
        roll = $urandom_range(99);
        case (sb.phase)
            PH_POLL:
                return make_req(FUNC_DONE, $urandom,
                                (roll < 55) ? BYTE_IDLE : 8'($urandom_range(255)));
            PH_TOKEN:
                return make_req(FUNC_DONE, $urandom,
                                (roll < 45) ? BYTE_TOKEN : 8'($urandom_range(255)));
            default:
                return make_req(FUNC_DONE, $urandom, 8'($urandom_range(255)));
        endcase
    endfunction

    // One clock edge: take results, take requests, drive both handshakes
    task automatic service_cycle();
        bit took_req;
        bit took_res;
        bit calm;
        took_res = res_if.valid && res_if.ready;
        took_req = req_if.valid && req_if.ready;
        if (took_res)
            sb.check_result(res_if.data);
        if (took_req && sb.note_request(req_if.data))
            real_items++;
        calm = (real_items >= CALM_FIRST) && (real_items < CALM_LAST);

        // Hold the current item until accepted, then offer the next or idle
        if (took_req || !req_if.valid) begin
            if (real_items >= ITEM_TARGET && !in_script) begin
                req_if.valid <= 1'b0;
                stim_done = 1'b1;
            end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
                req_if.valid <= 1'b0;
            end else begin
                req_if.data  <= next_request();
                req_if.valid <= 1'b1;
            end
        end
        res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

        if (took_req || took_res)
            stall_cycles = 0;
        else if (req_if.valid || sb.expected_q.size() > 0)
            stall_cycles++;
    endtask

    // Main sequence: reset, directed items, random items, drain
    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        res_if.ready = 1'b0;
        sb = new();
        script_q.push_back(make_req(FUNC_DONE,  32'h0,         8'hA5));
        script_q.push_back(make_req(FUNC_FETCH, 32'h0,         8'h00));
        script_q.push_back(make_req(FUNC_OPEN,  32'hFFFF_FFFF, 8'h00));
        script_q.push_back(make_req(FUNC_FETCH, 32'h0,         8'hFF));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!stim_done || sb.expected_q.size() > 0) begin
            @(posedge i_clk);
            service_cycle();
        end
        repeat (DRAIN_CYCLES) begin
            @(posedge i_clk);
            service_cycle();
        end
        $display("checked %0d result items from %0d active request items",
                 sb.n_checked, real_items);
        $display("%0d data bytes, %0d command replies, %0d inits, %0d block crossings, %0d wraps",
                 sb.n_data, sb.n_replies, sb.n_inits, sb.n_crossings, sb.n_wraps);
        if (sb.errors == 0) begin
            $display("PASS sd_spi_block_reader");
        end else begin
            $display("FAIL sd_spi_block_reader");
        end
        $finish;
    end

    // Watchdog: end the run when no item moves for too long
    initial begin
        do @(posedge i_clk); while (stall_cycles < STALL_LIMIT);
        $display("FAIL sd_spi_block_reader");
        $finish;
    end

endmodule
